/* sv/raycast_wall_texture_column_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the wall texture column block
// Short forms for the concurrent checks on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef RAYCAST_WALL_TEXTURE_COLUMN_ASSERT_SVH
`define RAYCAST_WALL_TEXTURE_COLUMN_ASSERT_SVH

// The condition holds at every rising edge out of reset.
`define RWTC_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define RWTC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RWTC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/rwtc_pkg.sv */
// ----------------------------------------------------------------------------
// rwtc_pkg
// Shared constants, result kinds and controller/datapath interface types.
// ----------------------------------------------------------------------------
package rwtc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int ROW_BITS  = 12;
    localparam int TEX_BITS  = 10;
    localparam int DIV_BITS  = 32;

    // Result kinds carried on m_tuser.
    localparam logic [1:0] KIND_SUMMARY = 2'd0;
    localparam logic [1:0] KIND_PIXEL   = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    // Texture selects.
    localparam logic [1:0] TEX_NORTH = 2'd0;
    localparam logic [1:0] TEX_SOUTH = 2'd1;
    localparam logic [1:0] TEX_WEST  = 2'd2;
    localparam logic [1:0] TEX_EAST  = 2'd3;

    // Input command codes.
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    // Configuration register indexes.
    localparam logic [1:0] REG_SCREEN_HEIGHT = 2'd0;
    localparam logic [1:0] REG_TEXTURE_WIDTH = 2'd1;
    localparam logic [1:0] REG_TEXTURE_LOG2  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_start;  // latch the ray data of an accepted start item
        logic pixel;       // produce one pixel result
        logic hit_mul;     // wall hit fraction
        logic texx_mul;    // texture column from the fraction
        logic mirror_lh;   // mirror texture column, launch line height divide
        logic range_go;    // draw range and offset, launch step divide
        logic commit;      // texture position, column state, summary result
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic div_done;
        logic out_free;
    } stat_t;

    // Effective (clamped) configuration.
    typedef struct packed {
        logic [12:0] height;
        logic [10:0] width;
        logic [3:0]  log2h;
    } cfg_t;

endpackage

/* sv/rwtc_div.sv */
// ----------------------------------------------------------------------------
// rwtc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rwtc_div (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [31:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] den_reg;
    logic [5:0]  cnt_reg;
    logic        done_reg;

    logic [32:0] shifted;
    logic [33:0] diff;

    // A zero divisor makes every trial subtraction succeed, so the quotient
    // comes out as all ones, which is the saturated value.
    assign shifted = {rem_reg, quo_reg[31]};
    assign diff    = {1'b0, shifted} - {2'b00, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= (cnt_reg == 6'd1);
            if (start) begin
                cnt_reg <= 6'(rwtc_pkg::DIV_BITS);
            end else if (cnt_reg != 6'd0) begin
                cnt_reg <= cnt_reg - 6'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (cnt_reg != 6'd0) begin
            if (!diff[33]) begin
                rem_reg <= diff[31:0];
                quo_reg <= {quo_reg[30:0], 1'b1};
            end else begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[30:0], 1'b0};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* sv/rwtc_ctrl.sv */
// ----------------------------------------------------------------------------
// rwtc_ctrl
// Sequencer for start items; pixel items are served straight from idle.
// ----------------------------------------------------------------------------
module rwtc_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    input  logic              in_cmd,
    input  rwtc_pkg::stat_t   stat,
    output logic              s_tready,
    output rwtc_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HIT,
        ST_TEXX,
        ST_MIRROR,
        ST_LH_WAIT,
        ST_RANGE,
        ST_STEP_WAIT,
        ST_COMMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == ST_IDLE) && stat.out_free;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cmd            = '0;
        state_next     = state_reg;
        cmd.load_start = accept && (in_cmd == rwtc_pkg::CMD_START);
        cmd.pixel      = accept && (in_cmd == rwtc_pkg::CMD_PIXEL);
        case (state_reg)
            ST_IDLE: begin
                if (cmd.load_start) begin
                    state_next = ST_HIT;
                end
            end
            ST_HIT: begin
                cmd.hit_mul = 1'b1;
                state_next  = ST_TEXX;
            end
            ST_TEXX: begin
                cmd.texx_mul = 1'b1;
                state_next   = ST_MIRROR;
            end
            ST_MIRROR: begin
                cmd.mirror_lh = 1'b1;
                state_next    = ST_LH_WAIT;
            end
            ST_LH_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_RANGE;
                end
            end
            ST_RANGE: begin
                cmd.range_go = 1'b1;
                state_next   = ST_STEP_WAIT;
            end
            ST_STEP_WAIT: begin
                if (stat.div_done) begin
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* sv/rwtc_datapath.sv */
// ----------------------------------------------------------------------------
// rwtc_datapath
// Column arithmetic, stripe state, pixel stepping and the result register.
// ----------------------------------------------------------------------------
module rwtc_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rwtc_pkg::cmd_t       cmd,
    output rwtc_pkg::stat_t      stat,
    input  rwtc_pkg::cfg_t       cfg,
    input  logic [11:0]          in_column,
    input  logic [31:0]          in_perp,
    input  logic                 in_side,
    input  logic signed [19:0]   in_dir_x,
    input  logic signed [19:0]   in_dir_y,
    input  logic [23:0]          in_player_x,
    input  logic [23:0]          in_player_y,
    input  logic                 m_tready,
    output logic                 m_valid,
    output logic [1:0]           m_kind,
    output logic [11:0]          m_column,
    output logic [11:0]          m_row,
    output logic [1:0]           m_select,
    output logic [9:0]           m_texel_x,
    output logic [9:0]           m_texel_y,
    output logic [19:0]          m_address,
    output logic [11:0]          m_first,
    output logic [11:0]          m_last_row,
    output logic                 m_last
);

    // Ray data latched at a start item.
    logic [11:0]        col_reg;
    logic [31:0]        perp_reg;
    logic signed [19:0] dir_reg;
    logic [23:0]        pos_reg;
    logic [1:0]         sel_reg;
    logic               mirror_reg;

    // Column intermediates.
    logic [31:0] frac_reg;
    logic [10:0] tx_raw_reg;
    logic [9:0]  tx_reg;
    logic [11:0] first_reg;
    logic [11:0] last_reg;
    logic [30:0] offset_reg;

    // Stripe state.
    logic        active_reg;
    logic [11:0] cur_col_reg;
    logic [11:0] cur_row_reg;
    logic [11:0] end_row_reg;
    logic [31:0] tpos_reg;
    logic [31:0] step_reg;
    logic [9:0]  cur_tx_reg;
    logic [1:0]  cur_sel_reg;

    // Result register.
    logic        m_valid_reg;
    logic [1:0]  m_kind_reg;
    logic [11:0] m_column_reg;
    logic [11:0] m_row_reg;
    logic [1:0]  m_select_reg;
    logic [9:0]  m_texel_x_reg;
    logic [9:0]  m_texel_y_reg;
    logic [19:0] m_address_reg;
    logic [11:0] m_first_reg;
    logic [11:0] m_last_row_reg;
    logic        m_last_reg;

    logic               dx_neg;
    logic               dy_neg;
    logic               dx_pos;
    logic [1:0]         sel_next;
    logic               mirror_next;
    logic signed [52:0] hit_prod;
    logic [31:0]        hit_base;
    logic [42:0]        texx_prod;
    logic [10:0]        tx_mirror;
    logic               div_start;
    logic [31:0]        div_dividend;
    logic [31:0]        div_divisor;
    logic               div_done;
    logic [31:0]        quo;
    logic [30:0]        half_l;
    logic [11:0]        half_h;
    logic [31:0]        last_sum;
    logic [11:0]        first_next;
    logic [11:0]        last_next;
    logic [30:0]        offset_next;
    logic [62:0]        pos_prod;
    logic [10:0]        ty_mask;
    logic [9:0]         ty;
    logic [19:0]        addr;
    logic [11:0]        row_next;
    logic               out_free;

    // Texture choice and mirroring from the hit side and the ray direction.
    assign dx_neg = in_dir_x[19];
    assign dy_neg = in_dir_y[19];
    assign dx_pos = !dx_neg && (in_dir_x != 20'sd0);
    assign sel_next = in_side ? (dy_neg ? rwtc_pkg::TEX_WEST : rwtc_pkg::TEX_EAST)
                              : (dx_neg ? rwtc_pkg::TEX_NORTH : rwtc_pkg::TEX_SOUTH);
    assign mirror_next = in_side ? dy_neg : dx_pos;

    // Wall hit fraction: the low 2F bits of pos + perp * dir.
    assign hit_prod = $signed({1'b0, perp_reg}) * dir_reg;
    assign hit_base = 32'({8'd0, pos_reg}) << rwtc_pkg::FRAC_BITS;
    assign texx_prod = frac_reg * 43'(cfg.width);
    assign tx_mirror = cfg.width - tx_raw_reg - 11'd1;

    // One divider serves the line height and the texture step.
    assign div_start    = cmd.mirror_lh || cmd.range_go;
    assign div_dividend = cmd.range_go
        ? (32'd1 << (5'(cfg.log2h) + 5'(rwtc_pkg::FRAC_BITS)))
        : (32'(cfg.height) << rwtc_pkg::FRAC_BITS);
    assign div_divisor  = cmd.range_go ? quo : perp_reg;

    rwtc_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (quo)
    );

    // Draw range from the line height held in the divider.
    assign half_l   = quo[31:1];
    assign half_h   = cfg.height[12:1];
    assign last_sum = {1'b0, half_l} + 32'(half_h);
    assign first_next  = ({19'd0, half_h} < half_l) ? 12'd0 : (half_h - half_l[11:0]);
    assign offset_next = ({19'd0, half_h} < half_l) ? (half_l - 31'(half_h)) : 31'd0;
    assign last_next   = (last_sum >= 32'(cfg.height)) ? 12'(cfg.height - 13'd1)
                                                       : last_sum[11:0];

    assign pos_prod = offset_reg * quo;

    // Pixel stepping.
    assign ty_mask  = (11'd1 << cfg.log2h) - 11'd1;
    assign ty       = tpos_reg[rwtc_pkg::FRAC_BITS +: 10] & ty_mask[9:0];
    assign addr     = (20'(ty) << cfg.log2h) + 20'(cur_tx_reg);
    assign row_next = cur_row_reg + 12'd1;

    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (cmd.load_start) begin
            col_reg    <= in_column;
            perp_reg   <= in_perp;
            dir_reg    <= in_side ? in_dir_x : in_dir_y;
            pos_reg    <= in_side ? in_player_x : in_player_y;
            sel_reg    <= sel_next;
            mirror_reg <= mirror_next;
        end
        if (cmd.hit_mul) begin
            frac_reg <= hit_base + hit_prod[31:0];
        end
        if (cmd.texx_mul) begin
            tx_raw_reg <= texx_prod[42:32];
        end
        if (cmd.mirror_lh) begin
            tx_reg <= mirror_reg ? tx_mirror[9:0] : tx_raw_reg[9:0];
        end
        if (cmd.range_go) begin
            first_reg  <= first_next;
            last_reg   <= last_next;
            offset_reg <= offset_next;
        end
    end

    // Stripe state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg  <= 1'b0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
            end_row_reg <= '0;
            tpos_reg    <= '0;
            step_reg    <= '0;
            cur_tx_reg  <= '0;
            cur_sel_reg <= '0;
        end else if (cmd.commit) begin
            active_reg  <= first_reg < last_reg;
            cur_col_reg <= col_reg;
            cur_row_reg <= first_reg;
            end_row_reg <= last_reg;
            tpos_reg    <= pos_prod[31:0];
            step_reg    <= quo;
            cur_tx_reg  <= tx_reg;
            cur_sel_reg <= sel_reg;
        end else if (cmd.pixel && active_reg) begin
            tpos_reg    <= tpos_reg + step_reg;
            cur_row_reg <= row_next;
            if (row_next == end_row_reg) begin
                active_reg <= 1'b0;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit || cmd.pixel) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_kind_reg     <= rwtc_pkg::KIND_SUMMARY;
            m_column_reg   <= col_reg;
            m_row_reg      <= '0;
            m_select_reg   <= sel_reg;
            m_texel_x_reg  <= tx_reg;
            m_texel_y_reg  <= '0;
            m_address_reg  <= '0;
            m_first_reg    <= first_reg;
            m_last_row_reg <= last_reg;
            m_last_reg     <= !(first_reg < last_reg);
        end else if (cmd.pixel) begin
            m_first_reg    <= '0;
            m_last_row_reg <= '0;
            if (active_reg) begin
                m_kind_reg    <= rwtc_pkg::KIND_PIXEL;
                m_column_reg  <= cur_col_reg;
                m_row_reg     <= cur_row_reg;
                m_select_reg  <= cur_sel_reg;
                m_texel_x_reg <= cur_tx_reg;
                m_texel_y_reg <= ty;
                m_address_reg <= addr;
                m_last_reg    <= (row_next == end_row_reg);
            end else begin
                m_kind_reg    <= rwtc_pkg::KIND_NONE;
                m_column_reg  <= '0;
                m_row_reg     <= '0;
                m_select_reg  <= '0;
                m_texel_x_reg <= '0;
                m_texel_y_reg <= '0;
                m_address_reg <= '0;
                m_last_reg    <= 1'b0;
            end
        end
    end

    assign stat.div_done = div_done;
    assign stat.out_free = out_free;

    assign m_valid    = m_valid_reg;
    assign m_kind     = m_kind_reg;
    assign m_column   = m_column_reg;
    assign m_row      = m_row_reg;
    assign m_select   = m_select_reg;
    assign m_texel_x  = m_texel_x_reg;
    assign m_texel_y  = m_texel_y_reg;
    assign m_address  = m_address_reg;
    assign m_first    = m_first_reg;
    assign m_last_row = m_last_row_reg;
    assign m_last     = m_last_reg;

endmodule

/* sv/raycast_wall_texture_column.sv */
// ----------------------------------------------------------------------------
// raycast_wall_texture_column
// Textured wall stripe setup and per-pixel texture stepping for a raycaster.
// ----------------------------------------------------------------------------
// A start item (s_tuser = 0) carries one screen column's ray hit; the block
// answers with one column summary giving the texture, the mirrored texture
// column and the clamped draw range, then goes busy. From acceptance to its
// summary a start item runs two divisions (line height, then texture step),
// one quotient bit per cycle on a single shared divider, with the multiplies
// and range arithmetic around them. No item is accepted during that time.
// Pixel items (s_tuser = 1) are served from idle, so a stripe streams one
// pixel per clock while the result side keeps taking them. A pixel item with
// no stripe pending returns a "no pixel pending" result. The user must write
// configuration through the APB-style port only while the block is idle; the
// block does not enforce this. Out-of-range values are clamped when used.
// ----------------------------------------------------------------------------
module raycast_wall_texture_column (
    input  logic         aclk,
    input  logic         aresetn,

    // Configuration port.
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,

    // Input items.
    input  logic         s_tvalid,
    output logic         s_tready,
    // column[11:0], perp_distance[43:12], wall_side[44], dir_x[64:45],
    // dir_y[84:65], player_x[108:85], player_y[132:109], zero pad[135:133]
    input  logic [135:0] s_tdata,
    // cmd
    input  logic         s_tuser,

    // Result items.
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_column[11:0], screen_row[23:12], texture_select[25:24],
    // texel_x[35:26], texel_y[45:36], texel_address[65:46],
    // draw_first[77:66], draw_last[89:78], zero pad[95:90]
    output logic [95:0]  m_tdata,
    // kind
    output logic [1:0]   m_tuser,
    // last
    output logic         m_tlast
);

    // Raw configuration registers, read back as stored (masked, not clamped).
    logic [12:0] screen_height_reg;
    logic [10:0] texture_width_reg;
    logic [3:0]  texture_log2_reg;

    rwtc_pkg::cfg_t  cfg;
    rwtc_pkg::cmd_t  cmd;
    rwtc_pkg::stat_t stat;

    logic        cfg_write;
    logic [1:0]  cfg_index;

    logic [11:0] r_column;
    logic [11:0] r_row;
    logic [1:0]  r_select;
    logic [9:0]  r_texel_x;
    logic [9:0]  r_texel_y;
    logic [19:0] r_address;
    logic [11:0] r_first;
    logic [11:0] r_last_row;

    // The register index comes from the word address; writes past the last
    // register are ignored.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            screen_height_reg <= 13'd480;
            texture_width_reg <= 11'd64;
            texture_log2_reg  <= 4'd6;
        end else if (cfg_write) begin
            case (cfg_index)
                rwtc_pkg::REG_SCREEN_HEIGHT: screen_height_reg <= pwdata[12:0];
                rwtc_pkg::REG_TEXTURE_WIDTH: texture_width_reg <= pwdata[10:0];
                rwtc_pkg::REG_TEXTURE_LOG2:  texture_log2_reg  <= pwdata[3:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_index)
            rwtc_pkg::REG_SCREEN_HEIGHT: prdata = 32'(screen_height_reg);
            rwtc_pkg::REG_TEXTURE_WIDTH: prdata = 32'(texture_width_reg);
            rwtc_pkg::REG_TEXTURE_LOG2:  prdata = 32'(texture_log2_reg);
            default:                     prdata = '0;
        endcase
    end

    // Clamp the configuration to the ranges the datapath supports: at least
    // two rows and at most 2^ROW_BITS, a texture width from one texel to
    // 2^TEX_BITS, and a texture height of at most 2^TEX_BITS.
    always_comb begin
        cfg.height = screen_height_reg;
        if (screen_height_reg < 13'd2) begin
            cfg.height = 13'd2;
        end else if (screen_height_reg > 13'(1 << rwtc_pkg::ROW_BITS)) begin
            cfg.height = 13'(1 << rwtc_pkg::ROW_BITS);
        end
        cfg.width = texture_width_reg;
        if (texture_width_reg < 11'd1) begin
            cfg.width = 11'd1;
        end else if (texture_width_reg > 11'(1 << rwtc_pkg::TEX_BITS)) begin
            cfg.width = 11'(1 << rwtc_pkg::TEX_BITS);
        end
        cfg.log2h = (texture_log2_reg > 4'(rwtc_pkg::TEX_BITS))
                    ? 4'(rwtc_pkg::TEX_BITS) : texture_log2_reg;
    end

    // The controller sequences start items and gates acceptance on the
    // result register being free.
    rwtc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_cmd   (s_tuser),
        .stat     (stat),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    rwtc_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg         (cfg),
        .in_column   (s_tdata[11:0]),
        .in_perp     (s_tdata[43:12]),
        .in_side     (s_tdata[44]),
        .in_dir_x    ($signed(s_tdata[64:45])),
        .in_dir_y    ($signed(s_tdata[84:65])),
        .in_player_x (s_tdata[108:85]),
        .in_player_y (s_tdata[132:109]),
        .m_tready    (m_tready),
        .m_valid     (m_tvalid),
        .m_kind      (m_tuser),
        .m_column    (r_column),
        .m_row       (r_row),
        .m_select    (r_select),
        .m_texel_x   (r_texel_x),
        .m_texel_y   (r_texel_y),
        .m_address   (r_address),
        .m_first     (r_first),
        .m_last_row  (r_last_row),
        .m_last      (m_tlast)
    );

    assign m_tdata = {6'd0, r_last_row, r_first, r_address, r_texel_y, r_texel_x,
                      r_select, r_row, r_column};

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`include "raycast_wall_texture_column_assert.svh"

    // Input is only taken when the result register can hold the answer.
    `RWTC_ASSERT_SAME(a_ready_needs_room, s_tready, (!m_tvalid || m_tready), "ready while result register full")

    // A start item puts the block into its busy sequence.
    `RWTC_ASSERT_NEXT(a_start_goes_busy, (s_tvalid && s_tready && (s_tuser == rwtc_pkg::CMD_START)), !s_tready, "ready right after a start item")

    // A summary's draw range is ordered, and last marks exactly an empty one.
    `RWTC_ASSERT_SAME(a_summary_range, (m_tvalid && (m_tuser == rwtc_pkg::KIND_SUMMARY)), ((m_tdata[77:66] <= m_tdata[89:78]) && (m_tlast == (m_tdata[77:66] == m_tdata[89:78]))), "summary draw range inconsistent")

endmodule

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for raycast_wall_texture_column
// Drives column start items and pixel items into the stream input, checks every
// result item field by field against an in-bench model of the wall stripe
// arithmetic, and steps the screen and texture registers through several
// settings (low and high extremes and out-of-range values) between phases.
// ----------------------------------------------------------------------------
module tb_top;

    // Number of random items after the directed table. Pixel runs are capped
    // so that one close wall on a tall screen cannot eat a whole phase.
    localparam int RANDOM_ITEMS   = 1650;
    localparam int NUM_PHASES     = 7;
    localparam int MAX_RUN        = 300;
    // A start item keeps the input side busy until its summary is out, so reaching
    // this limit with no handshake at all can only mean a hung block.
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int END_HOLD       = 150;

    // One input item. Apart from cmd, which travels on s_tuser, the field
    // order from the top down matches s_tdata.
    typedef struct packed {
        logic        cmd;
        logic [23:0] pos_y;
        logic [23:0] pos_x;
        logic [19:0] dir_y;
        logic [19:0] dir_x;
        logic        side;
        logic [31:0] perp;
        logic [11:0] column;
    } ray_item_t;

    // One result item, laid out as {m_tuser, m_tlast, m_tdata[89:0]}.
    typedef struct packed {
        logic [1:0]  kind;
        logic        tlast;
        logic [11:0] lastrow;
        logic [11:0] first;
        logic [19:0] addr;
        logic [9:0]  ty;
        logic [9:0]  tx;
        logic [1:0]  tsel;
        logic [11:0] row;
        logic [11:0] column;
    } column_result_t;

    // A row of the directed table. When typed is set, want holds the result
    // written out by hand; otherwise the stripe model supplies it.
    typedef struct packed {
        ray_item_t      item;
        logic           typed;
        column_result_t want;
    } directed_row_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         psel     = 1'b0;
    logic         penable  = 1'b0;
    logic         pwrite   = 1'b0;
    logic [3:0]   paddr    = '0;
    logic [31:0]  pwdata   = '0;
    logic [31:0]  prdata;
    logic         pready;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [135:0] s_tdata  = '0;
    logic         s_tuser  = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [95:0]  m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;

    raycast_wall_texture_column dut (.*);

    // 12 ns clock period.
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Register copies as the block should hold them (masked, not clamped).
    logic [12:0] cfg_height = 13'd480;
    logic [10:0] cfg_width  = 11'd64;
    logic [3:0]  cfg_log2   = 4'd6;

    // Stripe state of the model.
    logic        st_active  = 1'b0;
    logic [11:0] st_column  = '0;
    logic [11:0] st_row     = '0;
    logic [11:0] st_end     = '0;
    logic [31:0] st_pos     = '0;
    logic [31:0] st_step    = '0;
    logic [9:0]  st_texel_x = '0;
    logic [1:0]  st_tex     = '0;

    column_result_t pending_results[$];
    directed_row_t  directed_rows[$];
    int error_count    = 0;
    int items_sent     = 0;
    int send_idle_pct  = 13;
    int recv_stall_pct = 69;
    int idle_cycles    = 0;

    // Raw register values per phase after the first one. The third setting
    // carries junk in the unused upper bits, and the third and fourth carry
    // out-of-range values; the block has to mask on write and clamp on use.
    logic [31:0] phase_settings [6][3] = '{
        '{32'd2,          32'd1,          32'd0},
        '{32'd4096,       32'd1024,       32'd10},
        '{32'hFFFF_E000,  32'h0000_F800,  32'hFFFF_FFFF},
        '{32'h0000_1FFF,  32'h0000_07FF,  32'd11},
        '{32'd720,        32'd100,        32'd3},
        '{32'd480,        32'd64,         32'd6}
    };

    string field_names [10] = '{"kind", "last", "draw_last", "draw_first",
        "texel_address", "texel_y", "texel_x", "texture_select", "screen_row",
        "out_column"};

    // ------------------------------------------------------------------------
    // Stripe model
    // ------------------------------------------------------------------------

    function automatic logic [63:0] sat_quotient(logic [63:0] num, logic [63:0] den);
        logic [63:0] q;
        if (den == 64'd0) return 64'hFFFF_FFFF;
        q = num / den;
        return (q > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : q;
    endfunction

    function automatic logic [63:0] eff_height();
        logic [63:0] h;
        h = {51'd0, cfg_height};
        if (h < 64'd2) h = 64'd2;
        if (h > (64'd1 << rwtc_pkg::ROW_BITS)) h = 64'd1 << rwtc_pkg::ROW_BITS;
        return h;
    endfunction

    // Advances the stripe state by one accepted item and returns its result.
    function automatic column_result_t predict_column(ray_item_t it);
        logic [63:0] h, w, lg, texh, lh, half_h, half_l, first, last_row;
        logic [63:0] dx, dy, hit, tx, step, offset, prod, ty, addr;
        logic [11:0] row;
        column_result_t r;
        h = eff_height();
        w = {53'd0, cfg_width};
        if (w < 64'd1) w = 64'd1;
        if (w > (64'd1 << rwtc_pkg::TEX_BITS)) w = 64'd1 << rwtc_pkg::TEX_BITS;
        lg = (cfg_log2 > 4'(rwtc_pkg::TEX_BITS)) ? 64'(rwtc_pkg::TEX_BITS)
                                                  : {60'd0, cfg_log2};
        texh = 64'd1 << lg;
        r = '0;
        if (it.cmd == rwtc_pkg::CMD_START) begin
            dx = {{44{it.dir_x[19]}}, it.dir_x};
            dy = {{44{it.dir_y[19]}}, it.dir_y};
            lh = sat_quotient(h << rwtc_pkg::FRAC_BITS, {32'd0, it.perp});
            half_h = h >> 1;
            half_l = lh >> 1;
            first = (half_l > half_h) ? 64'd0 : half_h - half_l;
            last_row = half_l + half_h;
            if (last_row >= h) last_row = h - 64'd1;

            // The wall hit is exact: the position carries F fraction bits,
            // the distance times direction carries 2F, so the position is
            // lifted by F before the sum.
            if (it.side == 1'b0) begin
                r.tsel = it.dir_x[19] ? rwtc_pkg::TEX_NORTH : rwtc_pkg::TEX_SOUTH;
                hit = ({40'd0, it.pos_y} << rwtc_pkg::FRAC_BITS) + {32'd0, it.perp} * dy;
            end else begin
                r.tsel = it.dir_y[19] ? rwtc_pkg::TEX_WEST : rwtc_pkg::TEX_EAST;
                hit = ({40'd0, it.pos_x} << rwtc_pkg::FRAC_BITS) + {32'd0, it.perp} * dx;
            end
            hit = hit & ((64'd1 << (2 * rwtc_pkg::FRAC_BITS)) - 64'd1);
            tx = (hit * w) >> (2 * rwtc_pkg::FRAC_BITS);
            // East-facing x walls and south-facing y walls are seen mirrored.
            if ((it.side == 1'b0 && !it.dir_x[19] && it.dir_x != '0) ||
                (it.side == 1'b1 && it.dir_y[19]))
                tx = w - tx - 64'd1;

            step = sat_quotient(texh << rwtc_pkg::FRAC_BITS, lh);
            offset = first + half_l - half_h;
            prod = offset * step;

            st_column  = it.column;
            st_row     = first[11:0];
            st_end     = last_row[11:0];
            st_step    = step[31:0];
            st_pos     = prod[31:0];
            st_texel_x = tx[9:0];
            st_tex     = r.tsel;
            st_active  = first < last_row;

            r.kind    = rwtc_pkg::KIND_SUMMARY;
            r.column  = it.column;
            r.tx      = st_texel_x;
            r.first   = first[11:0];
            r.lastrow = last_row[11:0];
            r.tlast   = !st_active;
        end else if (!st_active) begin
            r.kind = rwtc_pkg::KIND_NONE;
        end else begin
            ty = ({32'd0, st_pos} >> rwtc_pkg::FRAC_BITS) & (texh - 64'd1);
            addr = (ty << lg) + {54'd0, st_texel_x};
            row = st_row;
            st_pos = st_pos + st_step;
            st_row = row + 12'd1;
            if (st_row == st_end) st_active = 1'b0;

            r.kind   = rwtc_pkg::KIND_PIXEL;
            r.column = st_column;
            r.row    = row;
            r.tsel   = st_tex;
            r.tx     = st_texel_x;
            r.ty     = ty[9:0];
            r.addr   = addr[19:0];
            r.tlast  = !st_active;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what,
                 got_v, want_v);
        error_count++;
    endtask

    function automatic logic [31:0] field_value(column_result_t r, int idx);
        case (idx)
            0: return 32'(r.kind);
            1: return 32'(r.tlast);
            2: return 32'(r.lastrow);
            3: return 32'(r.first);
            4: return 32'(r.addr);
            5: return 32'(r.ty);
            6: return 32'(r.tx);
            7: return 32'(r.tsel);
            8: return 32'(r.row);
            default: return 32'(r.column);
        endcase
    endfunction

    // Result monitor and watchdog. Outputs are sampled at the edge, before any
    // of this edge's updates land, so the order of processes does not matter.
    always @(posedge aclk) begin : result_monitor
        column_result_t got, want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                got = {m_tuser, m_tlast, m_tdata[89:0]};
                if (pending_results.size() == 0) begin
                    report_mismatch("result with nothing pending (kind)", 32'(got.kind),
                                    '0);
                end else begin
                    want = pending_results.pop_front();
                    for (int i = 0; i < 10; i++)
                        if (field_value(got, i) !== field_value(want, i))
                            report_mismatch(field_names[i], field_value(got, i),
                                            field_value(want, i));
                end
            end

            // Any handshake on either stream or the register port is progress.
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[%0t] no handshake for %0d cycles", $realtime, idle_cycles);
                $display("** raycast_wall_texture_column: FAILED **");
                $finish;
            end
        end
    end

    // The result side stalls at random at the current rate.
    always @(posedge aclk)
        m_tready <= (int'($urandom_range(99)) >= recv_stall_pct);

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    function automatic ray_item_t make_ray(logic cmd, logic [11:0] col, logic [31:0] perp,
                                           logic side, logic [19:0] dx, logic [19:0] dy,
                                           logic [23:0] px, logic [23:0] py);
        ray_item_t it;
        it.cmd    = cmd;
        it.column = col;
        it.perp   = perp;
        it.side   = side;
        it.dir_x  = dx;
        it.dir_y  = dy;
        it.pos_x  = px;
        it.pos_y  = py;
        return it;
    endfunction

    // A pixel request with every other field zero.
    function automatic ray_item_t pixel_ray();
        return make_ray(rwtc_pkg::CMD_PIXEL, '0, '0, 1'b0, '0, '0, '0, '0);
    endfunction

    function automatic void add_row(ray_item_t it, logic typed, column_result_t want);
        directed_row_t d;
        d.item  = it;
        d.typed = typed;
        d.want  = want;
        directed_rows.push_back(d);
    endfunction

    // A start item with random content. Most distances are picked so that the
    // line height is a few dozen rows, which keeps stripes short enough to be
    // walked to their end; the rest are far, close or arbitrary walls.
    function automatic ray_item_t random_start();
        logic [31:0] h, perp;
        int pick;
        h = 32'(eff_height());
        pick = int'($urandom_range(99));
        if (pick < 10)
            perp = $urandom();
        else if (pick < 15)
            perp = $urandom_range(0, 32'h0001_0000);
        else if (pick < 25)
            perp = $urandom_range(32'h0001_0000, 32'h0010_0000);
        else
            perp = ((h << rwtc_pkg::FRAC_BITS) / $urandom_range(1, 48))
                   + $urandom_range(0, 255);
        return make_ray(rwtc_pkg::CMD_START, 12'($urandom_range(0, 4095)), perp,
                        1'($urandom_range(0, 1)),
                        ($urandom_range(9) == 0) ? 20'd0 : 20'($urandom_range(0, 20'hFFFFF)),
                        ($urandom_range(9) == 0) ? 20'd0 : 20'($urandom_range(0, 20'hFFFFF)),
                        24'($urandom_range(0, 24'hFFFFFF)),
                        24'($urandom_range(0, 24'hFFFFFF)));
    endfunction

    // Pixel items carry random bits in the unused fields; the block must
    // ignore them.
    function automatic ray_item_t random_pixel();
        ray_item_t it;
        it = random_start();
        it.cmd = rwtc_pkg::CMD_PIXEL;
        return it;
    endfunction

    // Presents one item, holding valid high straight into the next item when
    // no gap is drawn, and queues its result once it is accepted.
    task automatic send_item(ray_item_t it, logic typed, column_result_t want);
        column_result_t predicted;
        while (int'($urandom_range(99)) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {3'b000, it.pos_y, it.pos_x, it.dir_y, it.dir_x, it.side, it.perp,
                     it.column};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_column(it);
        pending_results.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Holds the input side until every queued result has come back. Since
    // every item yields exactly one result, the block is idle afterwards.
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    // Register write, then a read back of the same register. psel stays high
    // across both transfers and drops for one cycle at the end.
    task automatic write_register(logic [1:0] idx, logic [31:0] raw);
        logic [31:0] stored;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= raw;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (idx)
            rwtc_pkg::REG_SCREEN_HEIGHT: cfg_height = raw[12:0];
            rwtc_pkg::REG_TEXTURE_WIDTH: cfg_width  = raw[10:0];
            default:                     cfg_log2   = raw[3:0];
        endcase
        stored = (idx == rwtc_pkg::REG_SCREEN_HEIGHT) ? {19'd0, cfg_height} :
                 (idx == rwtc_pkg::REG_TEXTURE_WIDTH) ? {21'd0, cfg_width} :
                                                        {28'd0, cfg_log2};
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== stored)
            report_mismatch($sformatf("read back of register %0d", idx), prdata, stored);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    // One random sequence: mostly a start followed by its whole stripe, with
    // cut-short stripes, trailing pixel requests past the end, lone pixel
    // requests and the odd full drain mixed in.
    task automatic run_sequence();
        int pick, run;
        if (items_sent < RANDOM_ITEMS / 3) begin
            send_idle_pct  = 13;
            recv_stall_pct = 69;
        end else if (items_sent < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct  = 69;
            recv_stall_pct = 13;
        end else begin
            send_idle_pct  = 0;
            recv_stall_pct = 0;
        end

        pick = int'($urandom_range(99));
        if (pick < 4) begin
            repeat ($urandom_range(1, 3)) send_item(random_pixel(), 1'b0, '0);
        end else if (pick < 7) begin
            wait_drained();
        end else begin
            send_item(random_start(), 1'b0, '0);
            run = st_active ? int'(st_end - st_row) : 0;
            if (run > MAX_RUN) run = MAX_RUN;
            pick = int'($urandom_range(99));
            if (pick < 10 && run > 0)
                run = int'($urandom_range(0, run - 1));
            else if (pick < 22)
                run += int'($urandom_range(1, 3));
            repeat (run) send_item(random_pixel(), 1'b0, '0);
        end
    endtask

    initial begin
        // Directed table, run under the reset values of the registers
        // (480 rows, 64 texels wide, 64 texels high).

        // Pixel request straight after reset: nothing pending.
        add_row(pixel_ray(), 1'b1,
                column_result_t'{kind: rwtc_pkg::KIND_NONE, default: '0});
        // Zero distance saturates the line height: full screen, zero step.
        add_row(make_ray(rwtc_pkg::CMD_START, '0, 32'd0, 1'b0, '0, '0, '0, '0), 1'b1,
                column_result_t'{kind: rwtc_pkg::KIND_SUMMARY,
                                 tsel: rwtc_pkg::TEX_SOUTH, lastrow: 12'd479,
                                 default: '0});
        add_row(pixel_ray(), 1'b1,
                column_result_t'{kind: rwtc_pkg::KIND_PIXEL, tsel: rwtc_pkg::TEX_SOUTH,
                                 default: '0});
        // Largest distance during an active stripe: the stripe is dropped and
        // the new one is empty, so its summary carries last.
        add_row(make_ray(rwtc_pkg::CMD_START, 12'hFFF, 32'hFFFF_FFFF, 1'b1, 20'd0,
                         20'h80000, '0, '0),
                1'b1,
                column_result_t'{kind: rwtc_pkg::KIND_SUMMARY, column: 12'hFFF,
                                 tsel: rwtc_pkg::TEX_WEST, tx: 10'd63,
                                 first: 12'd240, lastrow: 12'd240,
                                 tlast: 1'b1, default: '0});
        add_row(pixel_ray(), 1'b1,
                column_result_t'{kind: rwtc_pkg::KIND_NONE, default: '0});
        // Four-row stripe facing north, walked to its end and one past it.
        add_row(make_ray(rwtc_pkg::CMD_START, 12'd17, 32'd7864320, 1'b0, 20'hFFFFF,
                         20'h12345, 24'hABCDEF, 24'h123456), 1'b0, '0);
        repeat (5) add_row(pixel_ray(), 1'b0, '0);
        // Unit distance, south texture mirrored, positions at their maximum.
        add_row(make_ray(rwtc_pkg::CMD_START, 12'd2048, 32'h0001_0000, 1'b0, 20'h7FFFF,
                         20'h7FFFF, 24'hFFFFFF, 24'hFFFFFF), 1'b0, '0);
        repeat (3) add_row(pixel_ray(), 1'b0, '0);
        // East texture, cut short by the next start.
        add_row(make_ray(rwtc_pkg::CMD_START, 12'd1000, 32'h0010_0000, 1'b1, 20'h80000,
                         20'h00001, 24'hFFFFFF, 24'd0), 1'b0, '0);
        repeat (2) add_row(pixel_ray(), 1'b0, '0);
        // Smallest nonzero distance: huge line height, step rounds to zero.
        add_row(make_ray(rwtc_pkg::CMD_START, 12'd5, 32'd1, 1'b1, 20'h55555, 20'h2AAAA,
                         24'h0F0F0F, 24'hF0F0F0), 1'b0, '0);
        add_row(pixel_ray(), 1'b0, '0);

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
        items_sent = 0;

        // Random phases. Every change of settings waits for all results first;
        // this is also where the input side sits still until the block has
        // answered everything it took.
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                write_register(rwtc_pkg::REG_SCREEN_HEIGHT, phase_settings[p - 1][0]);
                write_register(rwtc_pkg::REG_TEXTURE_WIDTH, phase_settings[p - 1][1]);
                write_register(rwtc_pkg::REG_TEXTURE_LOG2,  phase_settings[p - 1][2]);
            end
            while (items_sent < RANDOM_ITEMS * (p + 1) / NUM_PHASES)
                run_sequence();
        end

        // Let the last results come back, then allow a margin for any result
        // the block should not produce.
        wait_drained();
        repeat (END_HOLD) @(posedge aclk);
        if (error_count == 0)
            $display("** raycast_wall_texture_column: PASSED **");
        else
            $display("** raycast_wall_texture_column: FAILED **");
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/rwtc_pkg.sv
sv/rwtc_div.sv
sv/rwtc_ctrl.sv
sv/rwtc_datapath.sv
sv/raycast_wall_texture_column.sv
test/tb_top.sv
